// ----- rtl/tov_pkg.sv -----
// Shared constants, codes and pipeline types for the 6x11 text overlay.
// No dependencies; imported by the overlay top level.
`timescale 1ns / 1ps
`default_nettype none

package tov_pkg;

  // Font and text geometry
  localparam int unsigned GlyphRows  = 11;
  localparam int unsigned GlyphCols  = 6;
  localparam int unsigned MaxTextLen = 64;
  localparam int unsigned FontDepth  = 256 * GlyphRows;
  localparam int unsigned TextAddrW  = $clog2(MaxTextLen);
  localparam int unsigned FontAddrW  = $clog2(FontDepth);

  // Field widths
  localparam int unsigned FuncW  = 2;
  localparam int unsigned PixW   = 8;
  localparam int unsigned CoordW = 11;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned DataW  = 8;
  localparam int unsigned DimW   = 12;
  localparam int unsigned LenW   = 7;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [DimW-1:0] MaxWidth     = 12'd2048;
  localparam logic [DimW-1:0] RowsConst    = 12'd11;
  localparam logic [LenW-1:0] MaxLenConst  = 7'd64;
  localparam logic [IdxW-1:0] FontDepthC   = 12'd2816;
  localparam logic [DataW-1:0] LeftBit     = 8'h80;

  // Division by six: off * 2731 >> 14 is exact for off below 2048
  localparam logic [11:0] DivSixMul   = 12'd2731;
  localparam int unsigned DivSixShift = 14;

  typedef enum logic [FuncW-1:0] {
    FuncPixel = 2'd0,
    FuncText  = 2'd1,
    FuncFont  = 2'd2
  } func_e;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgImageWidth  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgImageHeight = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgTextLength  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgPlaceTop    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgPlaceRight  = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgSolidBg     = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgFgValue     = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgBgValue     = 3'd7;

  typedef struct packed {
    func_e               func;
    logic [PixW-1:0]     pix;
    logic [CoordW-1:0]   col;
    logic [CoordW-1:0]   line;
    logic [IdxW-1:0]     idx;
    logic [DataW-1:0]    data;
    logic                inb;
    logic [3:0]          row;
    logic                colge;
    logic [CoordW-1:0]   off;
    logic [8:0]          ch;
    logic [2:0]          sub;
    logic                draw;
    logic [FontAddrW-1:0] addr;
    logic                fwe;
  } pipe_t;

endpackage

`default_nettype wire

// ----- rtl/tov_ram.sv -----
// Generic single-port RAM with registered read data.
// Standalone; used for the text and font stores of the overlay.
`timescale 1ns / 1ps
`default_nettype none

module tov_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 8,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] addr_i,
  input  logic [Width-1:0] wdata_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- rtl/text_overlay_6x11.sv -----
// 6x11 font text overlay for an 8-bit grayscale pixel stream.
// Depends on tov_pkg and tov_ram (text and font stores).
// A pixel word passes stage registers 1 to 6 and then the output register.
// Throughput: one word per cycle unless the output stalls; the six stage registers
// plus the output register advance independently, so bubbles close up in a stall.
// Reset: configuration registers return to defaults and the pipeline empties;
// both stores are undefined until written.
`timescale 1ns / 1ps
`default_nettype none

module text_overlay_6x11 (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // pixel and load words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [tov_pkg::FuncW-1:0]     func_i,
  input  logic [tov_pkg::PixW-1:0]      pixel_in_i,
  input  logic [tov_pkg::CoordW-1:0]    column_i,
  input  logic [tov_pkg::CoordW-1:0]    line_i,
  input  logic [tov_pkg::IdxW-1:0]      store_index_i,
  input  logic [tov_pkg::DataW-1:0]     store_data_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [tov_pkg::PixW-1:0]      pixel_out_o,
  // register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [tov_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [tov_pkg::CfgDataW-1:0]  cfg_data_i
);

  import tov_pkg::*;

  localparam int unsigned NumStages = 6;

  // Configuration registers
  logic [DimW-1:0] image_width_q, image_height_q;
  logic [LenW-1:0] text_length_q;
  logic            place_top_q, place_right_q, solid_bg_q;
  logic [PixW-1:0] fg_value_q, bg_value_q;

  // Placement figures, refreshed every cycle from the registers
  logic [DimW-1:0] w_eff, band_d, start_d, avail_d;
  logic [LenW-1:0] n_eff;
  logic [8:0]      n6;
  logic [DimW:0]   st_diff;
  logic            right_fits;
  logic [DimW-1:0] band_q, start_q, avail_q;
  logic [LenW-1:0] n_eff_q;
  logic            short_q;

  // Pipeline
  pipe_t                s_q [1:NumStages];
  pipe_t                s_d [1:NumStages];
  logic [NumStages:1]   v_q, v_d;
  logic [NumStages+1:1] en;
  logic                 out_v_q;
  logic [PixW-1:0]      out_q, out_d;

  // Stage arithmetic
  logic [DimW:0]        ldiff, cdiff;
  logic [22:0]          prod;
  logic [DimW-1:0]      six_ch;
  logic [FontAddrW-1:0] t12;
  logic                 lit;

  // Store ports
  logic                 txt_we, txt_re, fnt_we, fnt_re;
  logic [TextAddrW-1:0] txt_addr;
  logic [DataW-1:0]     txt_rd, fnt_rd;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      image_width_q  <= 12'd640;
      image_height_q <= 12'd480;
      text_length_q  <= '0;
      place_top_q    <= 1'b0;
      place_right_q  <= 1'b1;
      solid_bg_q     <= 1'b0;
      fg_value_q     <= 8'd255;
      bg_value_q     <= 8'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgImageWidth:  image_width_q  <= cfg_data_i;
        CfgImageHeight: image_height_q <= cfg_data_i;
        CfgTextLength:  text_length_q  <= cfg_data_i[LenW-1:0];
        CfgPlaceTop:    place_top_q    <= cfg_data_i[0];
        CfgPlaceRight:  place_right_q  <= cfg_data_i[0];
        CfgSolidBg:     solid_bg_q     <= cfg_data_i[0];
        CfgFgValue:     fg_value_q     <= cfg_data_i[PixW-1:0];
        CfgBgValue:     bg_value_q     <= cfg_data_i[PixW-1:0];
        default: ;
      endcase
    end
  end

  // Band row, text start column and room left for whole cells
  always_comb begin
    w_eff = (image_width_q > MaxWidth) ? MaxWidth : image_width_q;
    n_eff = (text_length_q > MaxLenConst) ? MaxLenConst : text_length_q;
    n6    = ({2'b00, n_eff} << 2) + ({2'b00, n_eff} << 1);
    st_diff    = {1'b0, w_eff} - {4'b0000, n6} - 13'd1;
    right_fits = place_right_q && !st_diff[DimW];
    start_d = right_fits ? st_diff[DimW-1:0] : '0;
    avail_d = right_fits ? ({3'b000, n6} + 12'd1) : w_eff;
    band_d  = place_top_q ? '0 : (image_height_q - RowsConst);
  end

  always_ff @(posedge clk_i) begin
    band_q  <= band_d;
    start_q <= start_d;
    avail_q <= avail_d;
    n_eff_q <= n_eff;
    short_q <= (image_height_q < RowsConst);
  end

  // Each stage advances when empty or when the one after it advances
  always_comb begin
    en[NumStages+1] = !out_v_q || !out_stall_i;
    for (int k = NumStages; k >= 1; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  assign in_stall_o = !en[1];

  always_comb begin
    ldiff  = '0;
    cdiff  = '0;
    prod   = '0;
    six_ch = '0;
    t12    = '0;
    for (int k = 1; k <= NumStages; k++) begin
      s_d[k] = '0;
    end

    // Stage 1: input register
    s_d[1].func = func_e'(func_i);
    s_d[1].pix  = pixel_in_i;
    s_d[1].col  = column_i;
    s_d[1].line = line_i;
    s_d[1].idx  = store_index_i;
    s_d[1].data = store_data_i;
    v_d[1]      = in_valid_i;

    // Stage 2: band test and offset from the text start
    s_d[2] = s_q[1];
    ldiff  = {2'b00, s_q[1].line} - {1'b0, band_q};
    cdiff  = {2'b00, s_q[1].col} - {1'b0, start_q};
    s_d[2].inb   = !short_q && !ldiff[DimW] && (ldiff[DimW-1:0] < RowsConst);
    s_d[2].row   = ldiff[3:0];
    s_d[2].colge = !cdiff[DimW];
    s_d[2].off   = cdiff[CoordW-1:0];
    v_d[2]       = v_q[1];

    // Stage 3: character number
    s_d[3] = s_q[2];
    prod   = {12'd0, s_q[2].off} * {11'd0, DivSixMul};
    s_d[3].ch = prod[22:DivSixShift];
    v_d[3]    = v_q[2];

    // Stage 4: column in cell, whole-cell and length checks (text store read)
    s_d[4] = s_q[3];
    six_ch = ({3'b000, s_q[3].ch} << 2) + ({3'b000, s_q[3].ch} << 1);
    s_d[4].sub  = s_q[3].off[2:0] - six_ch[2:0];
    s_d[4].draw = s_q[3].inb && s_q[3].colge
                  && (s_q[3].ch < {2'b00, n_eff_q})
                  && ((six_ch + 12'd6) <= avail_q);
    v_d[4] = v_q[3];

    // Stage 5: font address
    s_d[5] = s_q[4];
    t12    = {4'b0000, txt_rd};
    if (s_q[4].func == FuncPixel) begin
      s_d[5].addr = (t12 << 3) + (t12 << 1) + t12 + {8'b0, s_q[4].row};
    end else begin
      s_d[5].addr = s_q[4].idx;
    end
    s_d[5].fwe = (s_q[4].func == FuncFont) && (s_q[4].idx < FontDepthC);
    v_d[5]     = v_q[4];

    // Stage 6: font store read; drop load words here
    s_d[6] = s_q[5];
    v_d[6] = v_q[5] && (s_q[5].func == FuncPixel);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 1; k <= NumStages; k++) begin
        if (en[k]) begin
          v_q[k] <= v_d[k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 1; k <= NumStages; k++) begin
      if (en[k]) begin
        s_q[k] <= s_d[k];
      end
    end
  end

  // Text store is touched between stages 3 and 4, in word order
  assign txt_we   = v_q[3] && en[4] && (s_q[3].func == FuncText)
                    && (s_q[3].idx[IdxW-1:TextAddrW] == '0);
  assign txt_re   = v_q[3] && en[4] && (s_q[3].func == FuncPixel);
  assign txt_addr = (s_q[3].func == FuncPixel) ? s_q[3].ch[TextAddrW-1:0]
                                               : s_q[3].idx[TextAddrW-1:0];

  tov_ram #(
    .Depth (MaxTextLen),
    .Width (DataW)
  ) u_text_ram (
    .clk_i   (clk_i),
    .we_i    (txt_we),
    .re_i    (txt_re),
    .addr_i  (txt_addr),
    .wdata_i (s_q[3].data),
    .rdata_o (txt_rd)
  );

  // Font store is touched between stages 5 and 6
  assign fnt_we = v_q[5] && en[6] && s_q[5].fwe;
  assign fnt_re = v_q[5] && en[6] && (s_q[5].func == FuncPixel);

  tov_ram #(
    .Depth (FontDepth),
    .Width (DataW)
  ) u_font_ram (
    .clk_i   (clk_i),
    .we_i    (fnt_we),
    .re_i    (fnt_re),
    .addr_i  (s_q[5].addr),
    .wdata_i (s_q[5].data),
    .rdata_o (fnt_rd)
  );

  // Output stage: pick the glyph bit and the pixel value
  always_comb begin
    lit = |(fnt_rd & (LeftBit >> s_q[6].sub));
    if (s_q[6].draw && lit) begin
      out_d = fg_value_q;
    end else if (s_q[6].draw && solid_bg_q) begin
      out_d = bg_value_q;
    end else begin
      out_d = s_q[6].pix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (en[NumStages+1]) begin
      out_v_q <= v_q[NumStages];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NumStages+1]) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign pixel_out_o = out_q;

endmodule

`default_nettype wire

// ----- test/tb.sv -----
// Self-checking testbench for text_overlay_6x11: loads the text and font stores, then
// streams pixel words and checks each overlaid pixel against a local predictor.
// Depends on tov_pkg and the text_overlay_6x11 RTL.
`timescale 1ns / 1ps

module tb;
  import tov_pkg::*;

  localparam logic [FuncW-1:0] FuncUnused = 2'd3;
  localparam int unsigned DrainCycles = 12;
  localparam int unsigned CycleLimit  = 600000;
  localparam int unsigned PhaseItems  = 130;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [FuncW-1:0]    func_w = '0;
  logic [PixW-1:0]     pixel_in = '0;
  logic [CoordW-1:0]   column = '0;
  logic [CoordW-1:0]   pix_row = '0;
  logic [IdxW-1:0]     store_index = '0;
  logic [DataW-1:0]    store_data = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [PixW-1:0]     pixel_out;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data = '0;

  // Local copy of the registers and stores
  int unsigned img_width = 640;
  int unsigned img_height = 480;
  int unsigned text_len = 0;
  bit          band_top = 1'b0;
  bit          align_right = 1'b1;
  bit          solid_bg = 1'b0;
  logic [7:0]  fg_value = 8'd255;
  logic [7:0]  bg_value = 8'd0;
  logic [7:0]  text_mirror [MaxTextLen];
  bit          text_known [MaxTextLen];
  logic [7:0]  font_mirror [FontDepth];
  bit          font_known [FontDepth];

  logic [PixW-1:0] pixel_expect_q [$];
  logic [7:0]      glyph_codes [$];
  bit              glyph_loaded [256];
  logic [PixW-1:0] want_pixel;
  int unsigned     mismatch_count = 0;
  int unsigned     cycle_count = 0;
  bit              gaps_on = 1'b1;
  bit              stall_on = 1'b1;
  int unsigned     stall_run = 0;
  int unsigned     stall_pick;

  text_overlay_6x11 u_top (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func_w),
    .pixel_in_i    (pixel_in),
    .column_i      (column),
    .line_i        (pix_row),
    .store_index_i (store_index),
    .store_data_i  (store_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .pixel_out_o   (pixel_out),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("text_overlay_6x11 regression: fail");
      $finish;
    end
  end

  // Output stall: runs of random length, mostly short
  always @(posedge clk) begin
    if (stall_run != 0) begin
      stall_run = stall_run - 1;
    end else if (!stall_on) begin
      out_stall <= 1'b0;
    end else begin
      stall_pick = $urandom_range(0, 99);
      if (stall_pick < 50) begin
        out_stall <= 1'b0;
        stall_run = $urandom_range(0, 7);
      end else if (stall_pick < 85) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(0, 2);
      end else if (stall_pick < 97) begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(3, 11);
      end else begin
        out_stall <= 1'b1;
        stall_run = $urandom_range(20, 40);
      end
    end
  end

  // Result checker: compare each accepted word with the oldest pending pixel
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pixel_expect_q.size() == 0) begin
        $error("pixel_out: expected nothing, got %0d", pixel_out);
        mismatch_count++;
      end else begin
        want_pixel = pixel_expect_q.pop_front();
        if (pixel_out !== want_pixel) begin
          $error("pixel_out: expected %0d, got %0d", want_pixel, pixel_out);
          mismatch_count++;
        end
      end
    end
  end

  // Band top row, first text column and drawn width; 0 when the image is too short
  function automatic bit text_geometry(output int unsigned band, output int unsigned start,
                                       output int unsigned span);
    int unsigned w, n, drawn;
    w = (img_width > 32'(MaxWidth)) ? 32'(MaxWidth) : img_width;
    n = (text_len > MaxTextLen) ? MaxTextLen : text_len;
    band = 0;
    if (!band_top && img_height >= GlyphRows) band = img_height - GlyphRows;
    start = 0;
    if (align_right && w >= n * GlyphCols + 1) start = w - n * GlyphCols - 1;
    drawn = (start + GlyphCols > w) ? 0 : (w - start) / GlyphCols;
    if (drawn > n) drawn = n;
    span = drawn * GlyphCols;
    return img_height >= GlyphRows;
  endfunction

  function automatic bit glyph_cell(input logic [CoordW-1:0] col, input logic [CoordW-1:0] prow,
                                    output int unsigned pos, output int unsigned sub,
                                    output int unsigned row);
    int unsigned band, start, span, c, r;
    pos = 0;
    sub = 0;
    row = 0;
    c = 32'(col);
    r = 32'(prow);
    if (!text_geometry(band, start, span)) return 1'b0;
    if (r < band || r >= band + GlyphRows) return 1'b0;
    if (c < start || c >= start + span) return 1'b0;
    pos = (c - start) / GlyphCols;
    sub = (c - start) % GlyphCols;
    row = r - band;
    return 1'b1;
  endfunction

  function automatic logic [PixW-1:0] overlaid_pixel(input logic [PixW-1:0] pix,
                                                     input logic [CoordW-1:0] col,
                                                     input logic [CoordW-1:0] prow);
    int unsigned pos, sub, row, glyph;
    if (!glyph_cell(col, prow, pos, sub, row)) return pix;
    glyph = 32'(text_mirror[pos]) * GlyphRows + row;
    if ((font_mirror[glyph] & (LeftBit >> sub)) != 8'd0) return fg_value;
    if (solid_bg) return bg_value;
    return pix;
  endfunction

  // True unless the pixel would look up a store entry that was never loaded
  function automatic bit store_reads_known(input logic [CoordW-1:0] col,
                                           input logic [CoordW-1:0] prow);
    int unsigned pos, sub, row;
    if (!glyph_cell(col, prow, pos, sub, row)) return 1'b1;
    return text_known[pos] && font_known[32'(text_mirror[pos]) * GlyphRows + row];
  endfunction

  task automatic send_word(input logic [FuncW-1:0] f, input logic [PixW-1:0] pix,
                           input logic [CoordW-1:0] col, input logic [CoordW-1:0] prow,
                           input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    int unsigned pick, gap;
    in_valid    <= 1'b1;
    func_w      <= f;
    pixel_in    <= pix;
    column      <= col;
    pix_row     <= prow;
    store_index <= idx;
    store_data  <= data;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    case (f)
      FuncPixel: pixel_expect_q.push_back(overlaid_pixel(pix, col, prow));
      FuncText: begin
        if (32'(idx) < MaxTextLen) begin
          text_mirror[idx] = data;
          text_known[idx]  = 1'b1;
        end
      end
      FuncFont: begin
        if (32'(idx) < FontDepth) begin
          font_mirror[idx] = data;
          font_known[idx]  = 1'b1;
        end
      end
      default: ;
    endcase
    if (gaps_on) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) gap = 0;
      else if (pick < 85) gap = $urandom_range(1, 3);
      else if (pick < 97) gap = $urandom_range(4, 10);
      else gap = $urandom_range(20, 60);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  task automatic send_pixel(input logic [PixW-1:0] pix, input logic [CoordW-1:0] col,
                            input logic [CoordW-1:0] prow);
    send_word(FuncPixel, pix, col, prow, IdxW'($urandom_range(0, 4095)),
              DataW'($urandom_range(0, 255)));
  endtask

  task automatic send_load(input logic [FuncW-1:0] f, input logic [IdxW-1:0] idx,
                           input logic [DataW-1:0] data);
    send_word(f, PixW'($urandom_range(0, 255)), CoordW'($urandom_range(0, 2047)),
              CoordW'($urandom_range(0, 2047)), idx, data);
  endtask

  // Hold the input idle until every pending pixel is out, then let the pipe settle
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pixel_expect_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_regs(input int unsigned w, input int unsigned h, input int unsigned n,
                          input bit top, input bit align_r, input bit solid,
                          input logic [7:0] fg, input logic [7:0] bg);
    drain_results();
    write_reg(CfgImageWidth, w[CfgDataW-1:0]);
    write_reg(CfgImageHeight, h[CfgDataW-1:0]);
    write_reg(CfgTextLength, {5'd0, n[LenW-1:0]});
    write_reg(CfgPlaceTop, {11'd0, top});
    write_reg(CfgPlaceRight, {11'd0, align_r});
    write_reg(CfgSolidBg, {11'd0, solid});
    write_reg(CfgFgValue, {4'd0, fg});
    write_reg(CfgBgValue, {4'd0, bg});
    cfg_valid   <= 1'b0;
    img_width   = 32'(w[DimW-1:0]);
    img_height  = 32'(h[DimW-1:0]);
    text_len    = 32'(n[LenW-1:0]);
    band_top    = top;
    align_right = align_r;
    solid_bg    = solid;
    fg_value    = fg;
    bg_value    = bg;
  endtask

  task automatic send_random_pixel(input bit focused);
    int unsigned band, start, span, tries;
    bit has_band;
    logic [CoordW-1:0] col, prow;
    has_band = text_geometry(band, start, span);
    col = '0;
    prow = '0;
    for (tries = 0; tries < 6; tries++) begin
      if (focused && has_band) begin
        prow = CoordW'(band + $urandom_range(0, GlyphRows + 1) - 1);
        col  = CoordW'(start + $urandom_range(0, span + 3) - 2);
      end else begin
        prow = CoordW'($urandom_range(0, 2047));
        col  = CoordW'($urandom_range(0, 2047));
      end
      if (store_reads_known(col, prow)) break;
    end
    // fall back to the row just past the band, which wraps clear of it at the bottom
    if (!store_reads_known(col, prow)) prow = CoordW'(band + GlyphRows);
    send_pixel(PixW'($urandom_range(0, 255)), col, prow);
  endtask

  // Reset defaults: no text, so every pixel passes through
  task automatic test_reset_state();
    send_pixel(8'd0, 11'd0, 11'd0);
    send_pixel(8'd255, 11'd2047, 11'd2047);
    send_pixel(8'h5A, 11'd320, 11'd475);
  endtask

  // Fill the text store and a set of glyphs, plus writes the block must drop
  task automatic test_store_loads();
    logic [7:0] code, data;
    int unsigned row, pos;
    glyph_codes.push_back(8'd0);   glyph_codes.push_back(8'd255);
    glyph_codes.push_back(8'd1);   glyph_codes.push_back(8'd128);
    glyph_codes.push_back(8'd65);  glyph_codes.push_back(8'd170);
    glyph_codes.push_back(8'd85);
    foreach (glyph_codes[i]) glyph_loaded[glyph_codes[i]] = 1'b1;
    while (glyph_codes.size() < 12) begin
      code = 8'($urandom_range(0, 255));
      if (!glyph_loaded[code]) begin
        glyph_loaded[code] = 1'b1;
        glyph_codes.push_back(code);
      end
    end
    foreach (glyph_codes[i]) begin
      for (row = 0; row < GlyphRows; row++) begin
        data = 8'($urandom_range(0, 255));
        if (glyph_codes[i] == 8'd255 && row == 0) data = 8'hFF;
        if (glyph_codes[i] == 8'd255 && row == 1) data = 8'h00;
        send_load(FuncFont, IdxW'(32'(glyph_codes[i]) * GlyphRows + row), data);
      end
    end
    for (pos = 0; pos < MaxTextLen; pos++) begin
      if (pos == 0) code = 8'd0;
      else if (pos == MaxTextLen - 1) code = 8'd255;
      else code = glyph_codes[$urandom_range(0, glyph_codes.size() - 1)];
      send_load(FuncText, IdxW'(pos), code);
    end
    // out-of-range positions and the unused code leave the stores alone
    send_load(FuncText, 12'd64, 8'hFF);
    send_load(FuncText, 12'd4095, 8'h5A);
    send_load(FuncFont, 12'd2816, 8'hFF);
    send_load(FuncFont, 12'd4095, 8'hA5);
    send_load(FuncUnused, 12'd0, 8'hFF);
  endtask

  task automatic test_placement();
    // bottom band, right-aligned full text: columns 255..638, rows 469..479
    set_regs(640, 480, 64, 1'b0, 1'b1, 1'b1, 8'hC3, 8'h3C);
    send_pixel(8'h11, 11'd254, 11'd469);
    send_pixel(8'h22, 11'd255, 11'd469);
    send_pixel(8'h33, 11'd258, 11'd474);
    send_pixel(8'h44, 11'd638, 11'd479);
    send_pixel(8'h55, 11'd639, 11'd475);
    send_pixel(8'h66, 11'd400, 11'd468);
    send_pixel(8'h77, 11'd400, 11'd480);
    // top band, left-aligned, transparent background
    set_regs(640, 480, 5, 1'b1, 1'b0, 1'b0, 8'h00, 8'hFF);
    send_pixel(8'h88, 11'd0, 11'd0);
    send_pixel(8'h99, 11'd29, 11'd10);
    send_pixel(8'hAA, 11'd30, 11'd5);
    send_pixel(8'hBB, 11'd15, 11'd11);
  endtask

  task automatic test_edge_cases();
    // image shorter than a glyph: nothing drawn
    set_regs(640, 10, 64, 1'b1, 1'b0, 1'b1, 8'hFF, 8'h00);
    send_pixel(8'h12, 11'd0, 11'd0);
    send_pixel(8'h34, 11'd5, 11'd9);
    // exactly one band high, at the bottom, so the band starts at row 0
    set_regs(640, 11, 64, 1'b0, 1'b0, 1'b1, 8'h00, 8'hFF);
    send_pixel(8'h56, 11'd0, 11'd0);
    send_pixel(8'h78, 11'd383, 11'd10);
    send_pixel(8'h9A, 11'd384, 11'd5);
    send_pixel(8'hBC, 11'd10, 11'd11);
    // width and length beyond their caps
    set_regs(4095, 2048, 127, 1'b0, 1'b1, 1'b0, 8'hFF, 8'hFF);
    send_pixel(8'hDE, 11'd1662, 11'd2040);
    send_pixel(8'hF0, 11'd1663, 11'd2037);
    send_pixel(8'h0F, 11'd2046, 11'd2047);
    send_pixel(8'h1E, 11'd2047, 11'd2047);
    // text crossing the right edge: only three whole characters fit
    set_regs(20, 480, 5, 1'b1, 1'b0, 1'b1, 8'd77, 8'd200);
    send_pixel(8'h2D, 11'd17, 11'd0);
    send_pixel(8'h3C, 11'd18, 11'd3);
    set_regs(20, 480, 5, 1'b1, 1'b1, 1'b1, 8'd200, 8'd77);
    send_pixel(8'h4B, 11'd0, 11'd4);
    send_pixel(8'h5A, 11'd19, 11'd10);
    // one pixel wide image
    set_regs(1, 2048, 64, 1'b1, 1'b1, 1'b1, 8'h01, 8'hFE);
    send_pixel(8'h69, 11'd0, 11'd0);
  endtask

  task automatic test_random_traffic();
    int unsigned phase, item, pick, w, h, n;
    logic [IdxW-1:0] idx;
    logic [7:0] data;
    for (phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 5))
        0: w = 1;
        1: w = 2048;
        2: w = $urandom_range(2049, 4095);
        3: w = $urandom_range(6, 80);
        default: w = $urandom_range(1, 2048);
      endcase
      case ($urandom_range(0, 5))
        0: h = $urandom_range(1, 10);
        1: h = 11;
        2: h = 2048;
        default: h = $urandom_range(11, 2048);
      endcase
      case ($urandom_range(0, 5))
        0: n = 0;
        1: n = 64;
        2: n = $urandom_range(65, 127);
        3: n = $urandom_range(1, 8);
        default: n = $urandom_range(0, 64);
      endcase
      set_regs(w, h, n, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
               1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
               8'($urandom_range(0, 255)));
      for (item = 0; item < PhaseItems; item++) begin
        if (item % 50 == 0) begin
          gaps_on  = $urandom_range(0, 3) != 0;
          stall_on = $urandom_range(0, 3) != 0;
        end
        // hold the sender once mid-run until the pipe is empty
        if (phase == 5 && item == 75) drain_results();
        pick = $urandom_range(0, 99);
        if (pick < 66) begin
          send_random_pixel(1'b1);
        end else if (pick < 78) begin
          send_random_pixel(1'b0);
        end else if (pick < 88) begin
          idx  = ($urandom_range(0, 9) != 0) ? IdxW'($urandom_range(0, 63))
                                              : IdxW'($urandom_range(0, 4095));
          data = ($urandom_range(0, 4) != 0) ?
                 glyph_codes[$urandom_range(0, glyph_codes.size() - 1)] :
                 8'($urandom_range(0, 255));
          send_load(FuncText, idx, data);
        end else if (pick < 97) begin
          if ($urandom_range(0, 4) != 0) begin
            idx = IdxW'(32'(glyph_codes[$urandom_range(0, glyph_codes.size() - 1)]) *
                        GlyphRows + $urandom_range(0, GlyphRows - 1));
          end else begin
            idx = IdxW'($urandom_range(0, 4095));
          end
          send_load(FuncFont, idx, 8'($urandom_range(0, 255)));
        end else begin
          send_load(FuncUnused, IdxW'($urandom_range(0, 4095)), 8'($urandom_range(0, 255)));
        end
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_store_loads();
    test_placement();
    test_edge_cases();
    test_random_traffic();
    drain_results();
    if (mismatch_count == 0 && pixel_expect_q.size() == 0) begin
      $display("text_overlay_6x11 regression: pass");
    end else begin
      $display("text_overlay_6x11 regression: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/tov_pkg.sv
rtl/tov_ram.sv
rtl/text_overlay_6x11.sv
test/tb.sv
